// ----- hw/rtl/b64d_pkg.sv -----
package b64d_pkg;

   localparam int B64D_CHAR_W      = 8;
   localparam int B64D_SEXTET_W    = 6;
   localparam int B64D_GROUP_BYTES = 3;
   localparam int B64D_QUEUE_DEPTH = 4;

   // byte count of a closed group: 0 to 3
   typedef logic [1:0] b64d_count_type;

   typedef struct packed {
      logic [B64D_GROUP_BYTES-1:0][B64D_CHAR_W-1:0] bytes;
      b64d_count_type                               count;
   } b64d_group_type;

   typedef struct packed {
      logic valid;
      b64d_group_type group;
   } b64d_push_type;

   typedef struct packed {
      logic ready;
      logic empty;
      logic full;
   } b64d_status_type;

endpackage

// ----- hw/rtl/b64d_req_if.sv -----
interface b64d_req_if import b64d_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [B64D_CHAR_W-1:0] in_char;
   logic                   text_end;

   modport source (output valid, output in_char, output text_end, input ready);
   modport sink   (input valid, input in_char, input text_end, output ready);
endinterface

// ----- hw/rtl/b64d_rsp_if.sv -----
interface b64d_rsp_if import b64d_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [B64D_CHAR_W-1:0] out_byte;
   logic                   run_last;

   modport source (output valid, output out_byte, output run_last, input ready);
   modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

// ----- hw/rtl/base64_decoder_top.sv -----
// Streaming base64 decoder.
//
// req_chan carries one text character per word (in_char) and text_end, set on
// the final character of a text. Characters fill groups of four slots; a
// character outside the alphabet (padding '=' too) fills a slot with zero and
// does not count as valid. A group closes on its fourth character or on
// text_end and yields zero to three bytes.
// rsp_chan carries one decoded byte per word; run_last marks the final byte
// of the group closed by one input word.
// A closed group is registered into the queue; its first byte is offered once
// earlier groups are delivered; the rest follow one per cycle unless stalled.
// Throughput: one character per cycle while req_chan.ready is high. A group of
// n characters yields at most n-1 bytes, so the output keeps pace; closed
// groups wait in a small group queue (QUEUE_DEPTH entries) drained one byte per
// cycle while the receiver is ready. When it stalls, the queue fills and
// req_chan.ready drops only once all QUEUE_DEPTH entries hold undelivered groups.
// Reset (synchronous, active high) empties the queue and opens a fresh group.
module base64_decoder_top import b64d_pkg::*; #(
   parameter int QUEUE_DEPTH = B64D_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   b64d_req_if.sink   req_chan,
   b64d_rsp_if.source rsp_chan
);

   b64d_push_type   push;
   b64d_status_type status;
   logic            req_accept;
   logic            rsp_accept;

   // hold off new characters only while every queue entry is taken
   assign req_chan.ready = status.ready;
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid = !status.empty;
   assign rsp_accept     = rsp_chan.valid && rsp_chan.ready;

   // gather slots and pack bytes when a group closes
   b64d_group u_group (
      .clock    (clock),
      .reset    (reset),
      .accept   (req_accept),
      .in_char  (req_chan.in_char),
      .text_end (req_chan.text_end),
      .push     (push)
   );

   // queue closed groups, advance one byte per accepted output word
   b64d_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .pop      (rsp_accept),
      .out_byte (rsp_chan.out_byte),
      .run_last (rsp_chan.run_last),
      .status   (status)
   );

`ifndef NO_ASSERTIONS
   // a reset always leaves the output channel empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("output valid after reset");

   // a group is never dropped: a closing push only happens with room in the queue
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !status.full)
      else $error("group pushed into a full queue");

   // bytes of one group follow without a gap
   a_group_cont: assert property (@(posedge clock) disable iff (reset)
      (rsp_accept && !rsp_chan.run_last) |=> rsp_chan.valid)
      else $error("group ended without run_last");
`endif

endmodule

// ----- hw/rtl/b64d_group.sv -----
module b64d_group import b64d_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [B64D_CHAR_W-1:0] in_char,
   input  logic                   text_end,
   output b64d_push_type          push
);

   localparam logic [1:0] LAST_POS = 2'd3;

   logic [B64D_SEXTET_W-1:0] slot0_ff, slot1_ff, slot2_ff;
   logic [B64D_SEXTET_W-1:0] slot0_in, slot1_in, slot2_in;
   logic [1:0]               pos_ff, pos_in;
   logic [1:0]               vcnt_ff, vcnt_in;

   logic [B64D_SEXTET_W-1:0] sx;
   logic                     ok;
   logic [B64D_SEXTET_W-1:0] s0, s1, s2, s3;
   logic [2:0]               total;
   logic                     close;
   b64d_count_type           nbytes;

   // map a character to its sextet; anything outside the alphabet maps to zero
   always_comb begin
      ok = 1'b1;
      sx = '0;
      if (in_char >= "A" && in_char <= "Z") begin
         sx = B64D_SEXTET_W'(in_char - 8'("A"));
      end else if (in_char >= "a" && in_char <= "z") begin
         sx = B64D_SEXTET_W'(in_char - 8'("a") + 8'd26);
      end else if (in_char >= "0" && in_char <= "9") begin
         sx = B64D_SEXTET_W'(in_char - 8'("0") + 8'd52);
      end else if (in_char == 8'("+")) begin
         sx = 6'd62;
      end else if (in_char == 8'("/")) begin
         sx = 6'd63;
      end else begin
         ok = 1'b0;
      end
   end

   // slots past the current one read as zero when the group closes
   always_comb begin
      s0 = (pos_ff == 2'd0) ? sx : slot0_ff;
      s1 = (pos_ff == 2'd1) ? sx : ((pos_ff > 2'd1) ? slot1_ff : '0);
      s2 = (pos_ff == 2'd2) ? sx : ((pos_ff > 2'd2) ? slot2_ff : '0);
      s3 = (pos_ff == LAST_POS) ? sx : '0;
      total = {1'b0, vcnt_ff} + {2'b00, ok};
      case (total)
         3'd2:    nbytes = 2'd1;
         3'd3:    nbytes = 2'd2;
         3'd4:    nbytes = 2'd3;
         default: nbytes = 2'd0;
      endcase
      close = (pos_ff == LAST_POS) || text_end;
   end

   always_comb begin
      push.valid          = accept && close && (nbytes != 2'd0);
      push.group.count    = nbytes;
      push.group.bytes[0] = {s0, s1[5:4]};
      push.group.bytes[1] = {s1[3:0], s2[5:2]};
      push.group.bytes[2] = {s2[1:0], s3};
   end

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      slot2_in = slot2_ff;
      pos_in   = pos_ff;
      vcnt_in  = vcnt_ff;
      if (accept) begin
         if (close) begin
            slot0_in = '0;
            slot1_in = '0;
            slot2_in = '0;
            pos_in   = '0;
            vcnt_in  = '0;
         end else begin
            case (pos_ff)
               2'd0:    slot0_in = sx;
               2'd1:    slot1_in = sx;
               default: slot2_in = sx;
            endcase
            pos_in  = pos_ff + 2'd1;
            vcnt_in = vcnt_ff + {1'b0, ok};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot0_ff <= '0;
         slot1_ff <= '0;
         slot2_ff <= '0;
         pos_ff   <= '0;
         vcnt_ff  <= '0;
      end else begin
         slot0_ff <= slot0_in;
         slot1_ff <= slot1_in;
         slot2_ff <= slot2_in;
         pos_ff   <= pos_in;
         vcnt_ff  <= vcnt_in;
      end
   end

endmodule

// ----- hw/rtl/b64d_queue.sv -----
module b64d_queue import b64d_pkg::*; #(
   parameter int DEPTH = B64D_QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  b64d_push_type          push,
   input  logic                   pop,
   output logic [B64D_CHAR_W-1:0] out_byte,
   output logic                   run_last,
   output b64d_status_type        status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   b64d_group_type   mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0]       idx_ff, idx_in;

   b64d_group_type head;
   logic           head_done;
   logic           do_push;

   assign head = mem_ff[rd_ptr_ff];

   always_comb begin
      case (idx_ff)
         2'd0:    out_byte = head.bytes[0];
         2'd1:    out_byte = head.bytes[1];
         default: out_byte = head.bytes[2];
      endcase
      run_last  = (idx_ff == head.count - 2'd1);
      head_done = pop && run_last;
      do_push   = push.valid && !status.full;
   end

   assign status.empty = (cnt_ff == '0);
   assign status.full  = (cnt_ff == FULL_CNT);
   assign status.ready = !status.full;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      idx_in    = idx_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         if (head_done) begin
            rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
            idx_in    = '0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
      case ({do_push, head_done})
         2'b10:   cnt_in = cnt_ff + CNT_W'(1);
         2'b01:   cnt_in = cnt_ff - CNT_W'(1);
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.group;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
         idx_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
         idx_ff    <= idx_in;
      end
   end

endmodule
